// File: rtl/icrr_pkg.sv
// icrr_pkg: shared types and constants for the intron cut range rebuilder.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package icrr_pkg;

    localparam int unsigned PosW  = 32;
    localparam int unsigned CfgW  = 20;
    localparam int unsigned NeedW = CfgW + 2;   // 2*delta + min_remaining

    // Configuration register indexes
    localparam int unsigned CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CFG_INTRON_DELTA  = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_MIN_REMAINING = 1'd1;

    // Output queue: room for two results of one exon plus slack
    localparam int unsigned QDepth = 4;
    localparam int unsigned QPtrW  = $clog2(QDepth);
    localparam int unsigned QCntW  = $clog2(QDepth + 1);

    typedef struct packed {
        logic [PosW-1:0] range_start;
        logic [PosW-1:0] range_end;
        logic            last_range;
    } range_t;

    // Results of one exon, packed from slot 0 upwards
    typedef struct packed {
        logic [1:0] count;
        range_t     r0;
        range_t     r1;
    } push_t;

endpackage

// File: rtl/intron_cut_range_rebuilder.sv
// An accepted request is registered in the input register, and its result in the output queue.
// Throughput: one exon per cycle while the queue has room for two; an exon whose gap
// is cut and which is also the last one gives two results, which leave the 4-entry
// output queue one a cycle while m_tready is high. The input register takes a new
// request whenever the queue has room for two. Reset (rst_n, asynchronous, active low)
// clears the chain, both registers and the queue.
`timescale 1ns / 1ps

module intron_cut_range_rebuilder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [icrr_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [icrr_pkg::CfgW-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,   // [31:0] exon_start, [63:32] exon_end
    input  logic                          s_tlast,   // last_exon
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,   // [31:0] range_start, [63:32] range_end
    output logic                          m_tlast    // last_range
);
    import icrr_pkg::*;

    logic            in_valid_reg;
    logic [PosW-1:0] in_start_reg;
    logic [PosW-1:0] in_end_reg;
    logic            in_last_reg;
    logic            room2;
    logic            take;
    logic            s_accept;
    push_t           push;
    range_t          out_data;

    assign take     = in_valid_reg && room2;
    assign s_tready = !in_valid_reg || room2;
    assign s_accept = s_tvalid && s_tready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_start_reg <= s_tdata[31:0];
            in_end_reg   <= s_tdata[63:32];
            in_last_reg  <= s_tlast;
        end
    end

    icrr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .take       (take),
        .exon_start (in_start_reg),
        .exon_end   (in_end_reg),
        .last_exon  (in_last_reg),
        .push       (push)
    );

    icrr_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room2     (room2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {out_data.range_end, out_data.range_start};
    assign m_tlast = out_data.last_range;

endmodule

// File: rtl/icrr_core.sv
// icrr_core: chain state, configuration registers and the cut/bridge decision.
// Depends on icrr_pkg.
`timescale 1ns / 1ps

module icrr_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [icrr_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [icrr_pkg::CfgW-1:0]     cfg_data,
    input  logic                          take,
    input  logic [icrr_pkg::PosW-1:0]     exon_start,
    input  logic [icrr_pkg::PosW-1:0]     exon_end,
    input  logic                          last_exon,
    output icrr_pkg::push_t               push
);
    import icrr_pkg::*;

    logic [CfgW-1:0]  delta_reg;
    logic [CfgW-1:0]  min_rem_reg;
    logic             chain_open_reg, chain_open_next;
    logic [PosW-1:0]  run_start_reg, run_start_next;
    logic [PosW-1:0]  prev_end_reg;

    logic [PosW-1:0]  gap;
    logic [NeedW-1:0] need;
    logic             cut;
    logic [PosW-1:0]  delta_ext;

    // gap length = start - prev_end - 1, only meaningful when start > prev_end
    always_comb
    begin
        delta_ext = {{(PosW-CfgW){1'b0}}, delta_reg};
        gap       = exon_start - prev_end_reg - 32'd1;
        need      = {1'b0, delta_reg, 1'b0} + {2'b00, min_rem_reg};
        cut       = chain_open_reg && (exon_start > prev_end_reg)
                    && (gap >= {{(PosW-NeedW){1'b0}}, need});
    end

    // next chain state and the results of this exon
    always_comb
    begin
        run_start_next  = run_start_reg;
        chain_open_next = chain_open_reg;
        if (!chain_open_reg)
        begin
            run_start_next  = exon_start;
            chain_open_next = 1'b1;
        end
        else if (cut)
        begin
            run_start_next = exon_start - delta_ext;
        end
        if (last_exon)
        begin
            chain_open_next = 1'b0;
        end

        push.r0.range_start = run_start_reg;
        push.r0.range_end   = prev_end_reg + delta_ext;
        push.r0.last_range  = 1'b0;
        push.r1.range_start = run_start_next;
        push.r1.range_end   = exon_end;
        push.r1.last_range  = 1'b1;
        if (!cut)
        begin
            push.r0 = push.r1;
        end
        push.count = 2'd0;
        if (take)
        begin
            push.count = {1'b0, cut} + {1'b0, last_exon};
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg   <= '0;
            min_rem_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INTRON_DELTA:  delta_reg   <= cfg_data;
                CFG_MIN_REMAINING: min_rem_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // chain state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_open_reg <= 1'b0;
            run_start_reg  <= '0;
            prev_end_reg   <= '0;
        end
        else if (take)
        begin
            chain_open_reg <= chain_open_next;
            run_start_reg  <= run_start_next;
            prev_end_reg   <= exon_end;
        end
    end

endmodule

// File: rtl/icrr_out_queue.sv
// icrr_out_queue: small result queue, up to two pushes and one pop per cycle.
// Depends on icrr_pkg.
`timescale 1ns / 1ps

module icrr_out_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  icrr_pkg::push_t push,
    output logic            room2,
    output logic            out_valid,
    input  logic            out_ready,
    output icrr_pkg::range_t out_data
);
    import icrr_pkg::*;

    range_t           mem_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0] count_reg, count_next;
    logic [QPtrW-1:0] wr_ptr_1;
    logic             pop;

    always_comb
    begin
        pop         = out_valid && out_ready;
        wr_ptr_1    = wr_ptr_reg + {{(QPtrW-1){1'b0}}, 1'b1};
        wr_ptr_next = wr_ptr_reg + push.count[QPtrW-1:0];
        rd_ptr_next = rd_ptr_reg + {{(QPtrW-1){1'b0}}, pop};
        count_next  = count_reg + {{(QCntW-2){1'b0}}, push.count}
                      - {{(QCntW-1){1'b0}}, pop};
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign room2     = (count_reg <= QCntW'(QDepth - 2));

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_1] <= push.r1;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/icrr_checker.sv
// icrr_checker: port-level assertions for the intron cut range rebuilder.
// Depends on icrr_pkg; bound to intron_cut_range_rebuilder below.
`timescale 1ns / 1ps

module icrr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [63:0]                   m_tdata,
    input logic                          m_tlast
);
    import icrr_pkg::*;

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // input back-pressure only while results are waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // no result appears without a recent request
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && !s_acc && !$past(s_acc) |=> !m_tvalid)
        else $error("result appeared without a request");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result pending after reset");

endmodule

bind intron_cut_range_rebuilder icrr_checker u_icrr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
